FILE: rtl/frs_pkg.sv
package frs_pkg;

    // Payload length limit; a length field at or above this is a length error
    localparam int unsigned MAX_PAYLOAD = 64;

    // Status codes reported with every byte
    localparam logic [2:0] ST_HUNT   = 3'd0;
    localparam logic [2:0] ST_FRAME  = 3'd1;
    localparam logic [2:0] ST_GOOD   = 3'd2;
    localparam logic [2:0] ST_BADSUM = 3'd3;
    localparam logic [2:0] ST_BADLEN = 3'd4;

    // Byte classes handed from the parser front to the execution back
    localparam logic [3:0] K_HUNT    = 4'd0;
    localparam logic [3:0] K_HEADER  = 4'd1;
    localparam logic [3:0] K_DEV_LO  = 4'd2;
    localparam logic [3:0] K_DEV_HI  = 4'd3;
    localparam logic [3:0] K_CMD_LO  = 4'd4;
    localparam logic [3:0] K_CMD_HI  = 4'd5;
    localparam logic [3:0] K_LEN_OK  = 4'd6;
    localparam logic [3:0] K_LEN_BAD = 4'd7;
    localparam logic [3:0] K_DATA    = 4'd8;
    localparam logic [3:0] K_CHECK   = 4'd9;

    // One classified byte
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic [7:0] index;
    } t_req;

endpackage

FILE: rtl/frs_front.sv
module frs_front
    import frs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    output t_req       o_req
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_DEV   = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    logic [7:0] r_header;
    logic [2:0] r_phase, n_phase;
    logic       r_high_next, n_high_next;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic       w_len_bad;

    assign w_len_bad = {1'b0, i_rx_byte} >= 9'(MAX_PAYLOAD);

    // Classify the byte and advance the frame position
    always_comb begin
        n_phase     = r_phase;
        n_high_next = r_high_next;
        n_pos       = r_pos;
        n_len       = r_len;
        o_req.kind  = K_HUNT;
        o_req.data  = i_rx_byte;
        o_req.index = 8'd0;
        case (r_phase)
            PH_DEV: begin
                o_req.kind  = r_high_next ? K_DEV_HI : K_DEV_LO;
                n_high_next = !r_high_next;
                if (r_high_next) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                o_req.kind  = r_high_next ? K_CMD_HI : K_CMD_LO;
                n_high_next = !r_high_next;
                if (r_high_next) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_pos = 8'd0;
                n_len = i_rx_byte;
                if (w_len_bad) begin
                    o_req.kind = K_LEN_BAD;
                    n_phase    = PH_HUNT;
                end else begin
                    o_req.kind = K_LEN_OK;
                    n_phase    = (i_rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                o_req.kind  = K_DATA;
                o_req.index = r_pos;
                n_pos       = r_pos + 8'd1;
                if (n_pos >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_req.kind = K_CHECK;
                n_phase    = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_rx_byte == r_header) begin
                    o_req.kind  = K_HEADER;
                    n_phase     = PH_DEV;
                    n_high_next = 1'b0;
                    n_pos       = 8'd0;
                end
            end
        endcase
    end

    // Hold the parse state until a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= 8'd170;
            r_phase     <= PH_HUNT;
            r_high_next <= 1'b0;
            r_pos       <= 8'd0;
            r_len       <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_header <= i_cfg_wr_data;
            end
            if (i_take) begin
                r_phase     <= n_phase;
                r_high_next <= n_high_next;
                r_pos       <= n_pos;
                r_len       <= n_len;
            end
        end
    end

endmodule

FILE: rtl/frs_queue.sv
module frs_queue
    import frs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    input  logic i_pop,
    output t_req o_req,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);

    t_req            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;

    assign o_full  = r_count == (PtrW+1)'(Depth);
    assign o_empty = r_count == '0;
    assign o_req   = r_mem[r_rd_ptr];

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PtrW+1)'(1);
                2'b01:   r_count <= r_count - (PtrW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/frs_back.sv
module frs_back
    import frs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_req        i_req,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [15:0] o_device_id,
    output logic [15:0] o_command_id,
    output logic [7:0]  o_frame_length,
    output logic [15:0] o_frames_seen,
    output logic [15:0] o_frames_bad
);

    logic        r_valid;
    logic [2:0]  r_status, n_status;
    logic        r_pvalid, n_pvalid;
    logic [7:0]  r_pbyte, n_pbyte;
    logic [7:0]  r_pindex, n_pindex;
    logic [15:0] r_dev, n_dev;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_good, n_good;
    logic [15:0] r_bad, n_bad;
    logic [7:0]  w_sum_add;

    assign w_sum_add = r_sum + i_req.data;

    // Carry out one classified byte
    always_comb begin
        n_status = ST_FRAME;
        n_pvalid = 1'b0;
        n_pbyte  = 8'd0;
        n_pindex = 8'd0;
        n_dev    = r_dev;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_sum    = r_sum;
        n_good   = r_good;
        n_bad    = r_bad;
        case (i_req.kind)
            K_HEADER: begin
                n_status = ST_HUNT;
                n_sum    = 8'd0;
            end
            K_DEV_LO: begin
                n_sum = w_sum_add;
                n_dev = {8'd0, i_req.data};
            end
            K_DEV_HI: begin
                n_sum = w_sum_add;
                n_dev = {i_req.data, r_dev[7:0]};
            end
            K_CMD_LO: begin
                n_sum = w_sum_add;
                n_cmd = {8'd0, i_req.data};
            end
            K_CMD_HI: begin
                n_sum = w_sum_add;
                n_cmd = {i_req.data, r_cmd[7:0]};
            end
            K_LEN_OK: begin
                n_sum = w_sum_add;
                n_len = i_req.data;
            end
            K_LEN_BAD: begin
                n_status = ST_BADLEN;
                n_len    = i_req.data;
            end
            K_DATA: begin
                n_sum    = w_sum_add;
                n_pvalid = 1'b1;
                n_pbyte  = i_req.data;
                n_pindex = i_req.index;
            end
            K_CHECK: begin
                n_good = r_good + 16'd1;
                if (i_req.data == r_sum) begin
                    n_status = ST_GOOD;
                end else begin
                    n_status = ST_BADSUM;
                    n_bad    = r_bad + 16'd1;
                end
            end
            default: begin
                n_status = ST_HUNT;
            end
        endcase
    end

    // Drop the result once taken, load the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dev   <= 16'd0;
            r_cmd   <= 16'd0;
            r_len   <= 8'd0;
            r_sum   <= 8'd0;
            r_good  <= 16'd0;
            r_bad   <= 16'd0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
                r_dev   <= n_dev;
                r_cmd   <= n_cmd;
                r_len   <= n_len;
                r_sum   <= n_sum;
                r_good  <= n_good;
                r_bad   <= n_bad;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Per-byte result fields
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_pvalid <= n_pvalid;
            r_pbyte  <= n_pbyte;
            r_pindex <= n_pindex;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_payload_valid = r_pvalid;
    assign o_payload_byte  = r_pbyte;
    assign o_payload_index = r_pindex;
    assign o_device_id     = r_dev;
    assign o_command_id    = r_cmd;
    assign o_frame_length  = r_len;
    assign o_frames_seen   = r_good;
    assign o_frames_bad    = r_bad;

endmodule

FILE: rtl/frame_receiver_sum_checked.sv
// Serial frame receiver with additive checksum.
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per
// request. Output channel: o_valid / i_stall carry one result per byte: status,
// payload byte and index when the byte is payload, the current device id,
// command id and length, and the frame and checksum-error counters.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write the header byte value
// (170 after reset); write it only while no byte is in flight.
// Throughput: one byte per cycle while o_stall is low. A parser front
// classifies each byte in the cycle it is taken, a four-entry queue holds
// classified bytes, and the back end updates ids, checksum and counters
// into the output register. A taken byte is written into the queue, then
// loaded into the output register when that is empty or being taken.
// Receiver stall: the output register holds its result; the queue keeps
// taking bytes until its four entries are full, then o_stall rises.
// Reset (synchronous, active low): back to header hunting, ids, length,
// checksum and counters cleared, queue emptied, header value set to 170.
module frame_receiver_sum_checked
    import frs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [15:0] o_device_id,
    output logic [15:0] o_command_id,
    output logic [7:0]  o_frame_length,
    output logic [15:0] o_frames_seen,
    output logic [15:0] o_frames_bad
);

    t_req w_front_req;
    t_req w_queue_req;
    logic w_take;
    logic w_full;
    logic w_empty;
    logic w_load;

    // Take a request whenever the queue has room
    assign w_take  = i_valid && !w_full;
    assign o_stall = w_full;

    // Load the output register when it is empty or being taken
    assign w_load = !w_empty && (!o_valid || !i_stall);

    frs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (w_take),
        .i_rx_byte     (i_rx_byte),
        .o_req         (w_front_req)
    );

    frs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take),
        .i_req   (w_front_req),
        .i_pop   (w_load),
        .o_req   (w_queue_req),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    frs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .i_req           (w_queue_req),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_device_id     (o_device_id),
        .o_command_id    (o_command_id),
        .o_frame_length  (o_frame_length),
        .o_frames_seen   (o_frames_seen),
        .o_frames_bad    (o_frames_bad)
    );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import frs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [2:0] {
        P_HUNT, P_DEV, P_CMD, P_LEN, P_DATA, P_CHECK
    } t_rx_phase;

    typedef struct {
        logic [2:0]  status;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic [7:0]  pindex;
        logic [15:0] dev;
        logic [15:0] cmd;
        logic [7:0]  len;
        logic [15:0] seen;
        logic [15:0] bad;
    } t_byte_report;

    typedef struct {
        logic [7:0] data;
        int         gap;
    } t_tx_item;

    typedef logic [7:0] t_byte_list[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_payload_index;
    logic [15:0] o_device_id;
    logic [15:0] o_command_id;
    logic [7:0]  o_frame_length;
    logic [15:0] o_frames_seen;
    logic [15:0] o_frames_bad;

    // Parser state mirrored by the testbench
    logic [7:0]  hdr_value = 8'd170;
    t_rx_phase   rx_phase = P_HUNT;
    logic        id_high_next = 1'b0;
    logic [15:0] dev_id = 16'd0;
    logic [15:0] cmd_id = 16'd0;
    logic [7:0]  frame_len = 8'd0;
    logic [7:0]  data_pos = 8'd0;
    logic [7:0]  rx_sum = 8'd0;
    logic [15:0] frames_done = 16'd0;
    logic [15:0] frames_badsum = 16'd0;

    t_tx_item     tx_items[$];
    t_byte_report want_reports[$];

    int  tx_wait = 0;
    int  rx_wait = 0;
    int  rx_calm = 0;
    int  bytes_in = 0;
    int  reports_out = 0;
    int  mismatches = 0;
    int  cycles = 0;
    logic hold_off = 1'b0;

    frame_receiver_sum_checked u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_device_id     (o_device_id),
        .o_command_id    (o_command_id),
        .o_frame_length  (o_frame_length),
        .o_frames_seen   (o_frames_seen),
        .o_frames_bad    (o_frames_bad)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("t=%0t %s", $realtime, msg);
        mismatches++;
    endtask

    // Advance the mirrored parser by one byte and return what the block must report
    function automatic t_byte_report parse_rx_byte(input logic [7:0] b);
        t_byte_report r;
        r.status = ST_FRAME;
        r.pvalid = 1'b0;
        r.pbyte = 8'd0;
        r.pindex = 8'd0;
        case (rx_phase)
            P_DEV, P_CMD: begin
                rx_sum = rx_sum + b;
                if (id_high_next) begin
                    if (rx_phase == P_DEV) dev_id[15:8] = b;
                    else cmd_id[15:8] = b;
                    rx_phase = (rx_phase == P_DEV) ? P_CMD : P_LEN;
                end else begin
                    if (rx_phase == P_DEV) dev_id = {8'h00, b};
                    else cmd_id = {8'h00, b};
                end
                id_high_next = !id_high_next;
            end
            P_LEN: begin
                frame_len = b;
                data_pos = 8'd0;
                if (b >= MAX_PAYLOAD) begin
                    r.status = ST_BADLEN;
                    rx_phase = P_HUNT;
                end else begin
                    rx_sum = rx_sum + b;
                    rx_phase = (b == 8'd0) ? P_CHECK : P_DATA;
                end
            end
            P_DATA: begin
                rx_sum = rx_sum + b;
                r.pvalid = 1'b1;
                r.pbyte = b;
                r.pindex = data_pos;
                data_pos = data_pos + 8'd1;
                if (data_pos >= frame_len) rx_phase = P_CHECK;
            end
            P_CHECK: begin
                frames_done = frames_done + 16'd1;
                if (b == rx_sum) begin
                    r.status = ST_GOOD;
                end else begin
                    r.status = ST_BADSUM;
                    frames_badsum = frames_badsum + 16'd1;
                end
                rx_phase = P_HUNT;
            end
            default: begin
                r.status = ST_HUNT;
                rx_phase = P_HUNT;
                if (b == hdr_value) begin
                    rx_phase = P_DEV;
                    id_high_next = 1'b0;
                    rx_sum = 8'd0;
                    data_pos = 8'd0;
                end
            end
        endcase
        r.dev = dev_id;
        r.cmd = cmd_id;
        r.len = frame_len;
        r.seen = frames_done;
        r.bad = frames_badsum;
        return r;
    endfunction

    // Sender: offer queued bytes after their drawn gap, hold while stalled
    always @(posedge i_clk) begin
        logic     next_valid;
        t_tx_item head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                want_reports.push_back(parse_rx_byte(i_rx_byte));
                bytes_in++;
            end
            if (!i_valid || !o_stall) begin
                next_valid = 1'b0;
                if (tx_items.size() > 0) begin
                    if (tx_wait < tx_items[0].gap) begin
                        tx_wait++;
                    end else begin
                        head = tx_items.pop_front();
                        i_rx_byte <= head.data;
                        next_valid = 1'b1;
                        tx_wait = 0;
                    end
                end
                i_valid <= next_valid;
            end
        end
    end

    // Receiver: check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        t_byte_report want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                reports_out++;
                if (want_reports.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              reports_out));
                end else begin
                    want = want_reports.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  reports_out, o_status, want.status));
                    if (o_payload_valid !== want.pvalid)
                        report_mismatch($sformatf("result %0d payload_valid %0d, want %0d",
                                                  reports_out, o_payload_valid, want.pvalid));
                    if (o_payload_byte !== want.pbyte)
                        report_mismatch($sformatf("result %0d payload_byte %0h, want %0h",
                                                  reports_out, o_payload_byte, want.pbyte));
                    if (o_payload_index !== want.pindex)
                        report_mismatch($sformatf("result %0d payload_index %0d, want %0d",
                                                  reports_out, o_payload_index, want.pindex));
                    if (o_device_id !== want.dev)
                        report_mismatch($sformatf("result %0d device_id %0h, want %0h",
                                                  reports_out, o_device_id, want.dev));
                    if (o_command_id !== want.cmd)
                        report_mismatch($sformatf("result %0d command_id %0h, want %0h",
                                                  reports_out, o_command_id, want.cmd));
                    if (o_frame_length !== want.len)
                        report_mismatch($sformatf("result %0d frame_length %0d, want %0d",
                                                  reports_out, o_frame_length, want.len));
                    if (o_frames_seen !== want.seen)
                        report_mismatch($sformatf("result %0d frames_seen %0d, want %0d",
                                                  reports_out, o_frames_seen, want.seen));
                    if (o_frames_bad !== want.bad)
                        report_mismatch($sformatf("result %0d frames_bad %0d, want %0d",
                                                  reports_out, o_frames_bad, want.bad));
                end
                // Draw the stall before the next result; now and then run a calm stretch
                if (rx_calm > 0) begin
                    rx_calm--;
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 15);
                    if ($urandom_range(0, 29) == 0) rx_calm = 30;
                end
            end
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Long receiver hold-offs in the middle of random traffic to fill the block
    initial begin
        while (bytes_in < 100) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
        while (bytes_in < 260) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input bit fast);
        t_tx_item item;
        item.data = b;
        item.gap = fast ? 0 : $urandom_range(0, 15);
        tx_items.push_back(item);
    endtask

    // Append the checksum (unless the length is out of range), cut and queue the frame
    task automatic seal_and_queue(input t_byte_list frm, input bit corrupt, input int keep,
                                  input bit fast, output int n_queued);
        logic [7:0] sum;
        sum = 8'd0;
        if (frm[5] < MAX_PAYLOAD) begin
            for (int i = 1; i < frm.size(); i++) sum = sum + frm[i];
            if (corrupt) sum = sum ^ (8'h01 << $urandom_range(0, 7));
            frm.push_back(sum);
        end
        if (keep > 0 && keep < frm.size()) frm = frm[0:keep-1];
        foreach (frm[i]) queue_byte(frm[i], fast);
        n_queued = frm.size();
    endtask

    // Mostly well-formed frames with random content; some noise, cut frames and bad sums
    task automatic queue_random_traffic(input int n_bytes);
        t_byte_list frm;
        int done_n;
        int n;
        int sel;
        int len;
        int keep;
        bit fast;
        done_n = 0;
        while (done_n < n_bytes) begin
            fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                queue_byte(8'($urandom_range(0, 255)), fast);
            end else begin
                sel = $urandom_range(0, 15);
                if (sel == 0) len = 0;
                else if (sel == 1) len = MAX_PAYLOAD - 1;
                else if (sel == 2) len = MAX_PAYLOAD;
                else if (sel == 3) len = $urandom_range(MAX_PAYLOAD, 255);
                else len = $urandom_range(1, 8);
                frm = {hdr_value};
                repeat (4) frm.push_back(8'($urandom_range(0, 255)));
                frm.push_back(8'(len));
                if (len < MAX_PAYLOAD) repeat (len) frm.push_back(8'($urandom_range(0, 255)));
                keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frm.size()) : 0;
                seal_and_queue(frm, $urandom_range(0, 3) == 0, keep, fast, n);
                done_n += n;
            end
        end
    endtask

    // Wait until no byte is queued, offered or awaiting its result
    task automatic drain();
        do @(negedge i_clk);
        while (tx_items.size() != 0 || i_valid || want_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        hdr_value = value;
    endtask

    initial begin
        t_byte_list frm;
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ignored noise at both extremes, a good frame, a zero-length
        // frame with a bad checksum, and a length at the limit
        write_header(8'd170);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        frm = '{8'd170, 8'h34, 8'h12, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00};
        seal_and_queue(frm, 1'b0, 0, 1'b0, n);
        frm = '{8'd170, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        seal_and_queue(frm, 1'b1, 0, 1'b0, n);
        frm = '{8'd170, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'(MAX_PAYLOAD)};
        seal_and_queue(frm, 1'b0, 0, 1'b1, n);
        drain();

        // Random traffic under several header values, extremes included
        write_header(8'h00);
        queue_random_traffic(150);
        drain();
        write_header(8'hFF);
        queue_random_traffic(150);
        drain();
        write_header(8'($urandom_range(1, 254)));
        queue_random_traffic(150);
        drain();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/frs_pkg.sv
rtl/frs_front.sv
rtl/frs_queue.sv
rtl/frs_back.sv
rtl/frame_receiver_sum_checked.sv
tb/sv/testbench.sv
